@@ rtl/focal_plane_distortion_map_defines.svh @@
// Assertion macros for the focal-plane distortion map.
// Used by the top level only; define ASSERT_OFF to drop the checks.
`ifndef FOCAL_PLANE_DISTORTION_MAP_DEFINES_SVH
`define FOCAL_PLANE_DISTORTION_MAP_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off while in reset.
`define FPDM_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while in reset.
`define FPDM_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define FPDM_ASSERT_IMP(label, pre, post, msg)
`define FPDM_ASSERT_NXT(label, pre, post, msg)
`endif
`endif

@@ rtl/fpdm_pkg.sv @@
// Shared types, Q24.40 constants, saturating helpers and the micro-op program
// for the focal-plane distortion map. No dependencies.
package fpdm_pkg;

	localparam int QF       = 40;
	localparam int DIV_BITS = 104;  // numerator magnitude shifted by QF fits here
	localparam int CFG_W    = 32;
	localparam int PC_W     = 6;

	localparam logic [63:0]        QMAX  = 64'h7fff_ffff_ffff_ffff;
	localparam logic signed [64:0] MAX65 = 65'sh0_7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] ONE_Q = 64'sh0000_0100_0000_0000;
	localparam logic signed [63:0] CX0   = -64'sd44301413;
	localparam logic signed [63:0] CY0   = -64'sd19642665279;
	localparam logic signed [63:0] CY1   = -64'sd8002718417;
	localparam logic signed [63:0] CY2   = 64'sd62152973;

	localparam logic [2:0] CFG_PITCH  = 3'd0;
	localparam logic [2:0] CFG_LOFF   = 3'd1;
	localparam logic [2:0] CFG_TOL    = 3'd2;
	localparam logic [2:0] CFG_MAXATT = 3'd3;

	localparam logic [PC_W-1:0] PC_FWD  = 6'd0;
	localparam logic [PC_W-1:0] PC_INV  = 6'd14;
	localparam logic [PC_W-1:0] PC_LOOP = 6'd22;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_DIV, OP_CHK, OP_END
	} op_t;

	typedef enum logic [3:0] {
		R_X, R_Y, R_P, R_LO, R_UX, R_UY, R_XO, R_YO,
		R_Q, R_T1, R_T2, K_ONE, K_CX0, K_CY0, K_CY1, K_CY2
	} opnd_t;

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

	typedef struct packed {
		op_t   op;
		opnd_t a;
		opnd_t b;
		opnd_t dst;
	} instr_t;

	typedef struct packed {
		logic  load;
		logic  exec;
		op_t   op;
		opnd_t a;
		opnd_t b;
		opnd_t dst;
		logic  finish;
		logic  ok;
	} cmd_t;

	typedef struct packed {
		logic       done;
		logic       dz;
		logic       conv;
		logic [5:0] max_att;
	} stat_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] make(input logic neg, input logic [63:0] m);
		logic [63:0] mm;
		mm = (m > QMAX) ? QMAX : m;
		return neg ? $signed(64'(-mm)) : $signed(mm);
	endfunction

	function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
		logic signed [64:0] r;
		r = v;
		if (v > MAX65) r = MAX65;
		else if (v < -MAX65) r = -MAX65;
		return $signed(r[63:0]);
	endfunction

	function automatic instr_t prog(input logic [PC_W-1:0] pc);
		instr_t i;
		case (pc)
			// forward
			6'd0:  i = '{OP_DIV, R_Y,   R_P,   R_Q};
			6'd1:  i = '{OP_NEG, R_Q,   R_Q,   R_XO};
			6'd2:  i = '{OP_MUL, K_CY1, R_XO,  R_T1};
			6'd3:  i = '{OP_ADD, K_CY0, R_T1,  R_T2};
			6'd4:  i = '{OP_MUL, K_CY2, R_XO,  R_T1};
			6'd5:  i = '{OP_MUL, R_T1,  R_XO,  R_T1};
			6'd6:  i = '{OP_ADD, R_T2,  R_T1,  R_T2};
			6'd7:  i = '{OP_ADD, R_XO,  R_LO,  R_T1};
			6'd8:  i = '{OP_MUL, K_CX0, R_T1,  R_T1};
			6'd9:  i = '{OP_ADD, K_ONE, R_T1,  R_T1};
			6'd10: i = '{OP_MUL, R_X,   R_T1,  R_UX};
			6'd11: i = '{OP_ADD, R_Q,   R_T2,  R_T1};
			6'd12: i = '{OP_MUL, R_P,   R_T1,  R_UY};
			6'd13: i = '{OP_END, R_Q,   R_Q,   R_Q};
			// inverse: offsets from dy
			6'd14: i = '{OP_DIV, R_Y,   R_P,   R_Q};
			6'd15: i = '{OP_SUB, R_LO,  R_Q,   R_T1};
			6'd16: i = '{OP_MUL, K_CX0, R_T1,  R_XO};
			6'd17: i = '{OP_MUL, R_P,   K_CY0, R_T1};
			6'd18: i = '{OP_DIV, R_T1,  R_Y,   R_T1};
			6'd19: i = '{OP_SUB, R_T1,  K_CY1, R_T1};
			6'd20: i = '{OP_MUL, R_Q,   K_CY2, R_T2};
			6'd21: i = '{OP_ADD, R_T1,  R_T2,  R_YO};
			// inverse pass
			6'd22: i = '{OP_ADD, K_ONE, R_XO,  R_T1};
			6'd23: i = '{OP_DIV, R_X,   R_T1,  R_UX};
			6'd24: i = '{OP_ADD, K_ONE, R_YO,  R_T1};
			6'd25: i = '{OP_DIV, R_Y,   R_T1,  R_UY};
			6'd26: i = '{OP_DIV, R_UY,  R_P,   R_Q};
			6'd27: i = '{OP_SUB, R_LO,  R_Q,   R_T1};
			6'd28: i = '{OP_MUL, K_CX0, R_T1,  R_XO};
			6'd29: i = '{OP_MUL, R_P,   K_CY0, R_T1};
			6'd30: i = '{OP_DIV, R_T1,  R_UY,  R_T1};
			6'd31: i = '{OP_SUB, R_T1,  K_CY1, R_T1};
			6'd32: i = '{OP_MUL, R_Q,   K_CY2, R_T2};
			6'd33: i = '{OP_ADD, R_T1,  R_T2,  R_YO};
			6'd34: i = '{OP_ADD, K_ONE, R_XO,  R_T1};
			6'd35: i = '{OP_MUL, R_UX,  R_T1,  R_T2};
			6'd36: i = '{OP_ADD, K_ONE, R_YO,  R_T1};
			6'd37: i = '{OP_MUL, R_UY,  R_T1,  R_T1};
			6'd38: i = '{OP_SUB, R_T1,  R_Y,   R_T1};
			6'd39: i = '{OP_SUB, R_T2,  R_X,   R_T2};
			6'd40: i = '{OP_CHK, R_Q,   R_Q,   R_Q};
			default: i = '{OP_END, R_Q, R_Q, R_Q};
		endcase
		return i;
	endfunction

endpackage

@@ rtl/fpdm_div.sv @@
// Bit-serial restoring divider for Q24.40 magnitudes, one quotient bit a cycle.
// Depends on fpdm_pkg.
module fpdm_div import fpdm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        num,
	input  logic [63:0]        den,
	input  logic               neg,
	output logic               done,
	output logic               zero,
	output logic signed [63:0] quo
);

	logic                act_q, done_q, zero_q, neg_q;
	logic [6:0]          cnt_q;
	logic [DIV_BITS-1:0] n_q, qt_q;
	logic [63:0]         r_q, d_q;
	logic [64:0]         r2;
	logic                fits;

	assign r2   = {r_q, n_q[DIV_BITS-1]};
	assign fits = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				zero_q <= (den == 64'd0);
				act_q  <= (den != 64'd0);
				done_q <= (den == 64'd0);
				cnt_q  <= 7'(DIV_BITS - 1);
			end else if (act_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					act_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {num, {QF{1'b0}}};
			d_q   <= den;
			neg_q <= neg;
			r_q   <= '0;
			qt_q  <= '0;
		end else if (act_q) begin
			n_q  <= {n_q[DIV_BITS-2:0], 1'b0};
			qt_q <= {qt_q[DIV_BITS-2:0], fits};
			r_q  <= fits ? 64'(r2 - {1'b0, d_q}) : r2[63:0];
		end
	end

	assign done = done_q;
	assign zero = zero_q;
	assign quo  = make(neg_q, (qt_q[DIV_BITS-1:64] != '0) ? QMAX : qt_q[63:0]);

endmodule

@@ rtl/fpdm_dp.sv @@
// Datapath: configuration registers, working registers, saturating ALU,
// four-step 32x32 multiplier and the shared divider. Depends on fpdm_pkg, fpdm_div.
module fpdm_dp import fpdm_pkg::*; #(
	parameter int COORD_WIDTH     = 32,
	parameter int COORD_FRAC_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                   success
);

	localparam int K  = QF - COORD_FRAC_BITS;
	localparam int KL = (K > 0) ? K : 0;
	localparam int KR = (K < 0) ? -K : 0;
	localparam logic [63:0] LIM = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;

	logic [30:0]        pitch_q;
	logic signed [31:0] loff_q;
	logic [24:0]        tol_q;
	logic [5:0]         maxatt_q;

	logic signed [63:0] x_q, y_q, p_q, lo_q, ux_q, uy_q, xo_q, yo_q, q_q, t1_q, t2_q;
	logic [63:0]        tol64_q;

	logic signed [COORD_WIDTH-1:0] ox_q, oy_q;
	logic                          ok_q;

	logic signed [63:0] opnd [16];
	logic signed [63:0] a_val, b_val, alu_val, wr_val;
	logic               wr_en;
	opnd_t              wr_dst, dst_q;
	logic               done_q;

	logic [63:0]  ma_q, mb_q;
	logic         mneg_q, mact_q;
	logic [2:0]   mcnt_q;
	logic [127:0] acc_q;
	logic [63:0]  pp, mres;
	logic [7:0]   sh;
	logic signed [63:0] mul_val;

	logic               div_go, div_done, div_zero;
	logic signed [63:0] div_quo;

	function automatic logic signed [63:0] to_q(input logic signed [64:0] v);
		logic        neg;
		logic [64:0] m, s;
		neg = v[64];
		m   = neg ? 65'(-v) : 65'(v);
		if (m > (65'(QMAX) >> KL)) s = 65'(QMAX);
		else s = (m << KL) >> KR;
		return make(neg, s[63:0]);
	endfunction

	function automatic logic [COORD_WIDTH-1:0] from_q(input logic signed [63:0] v);
		logic        neg;
		logic [63:0] m, s, r;
		neg = v[63];
		m   = mag64(v);
		if (m > (QMAX >> KR)) s = QMAX;
		else s = (m >> KL) << KR;
		if (s > LIM) s = LIM;
		r = neg ? 64'(-s) : s;
		return r[COORD_WIDTH-1:0];
	endfunction

	// operand table: working registers and Q24.40 constants
	always_comb begin
		opnd[R_X]   = x_q;
		opnd[R_Y]   = y_q;
		opnd[R_P]   = p_q;
		opnd[R_LO]  = lo_q;
		opnd[R_UX]  = ux_q;
		opnd[R_UY]  = uy_q;
		opnd[R_XO]  = xo_q;
		opnd[R_YO]  = yo_q;
		opnd[R_Q]   = q_q;
		opnd[R_T1]  = t1_q;
		opnd[R_T2]  = t2_q;
		opnd[K_ONE] = ONE_Q;
		opnd[K_CX0] = CX0;
		opnd[K_CY0] = CY0;
		opnd[K_CY1] = CY1;
		opnd[K_CY2] = CY2;
	end

	assign a_val = opnd[cmd.a];
	assign b_val = opnd[cmd.b];

	always_comb begin
		case (cmd.op)
			OP_ADD:  alu_val = sat65(65'(a_val) + 65'(b_val));
			OP_SUB:  alu_val = sat65(65'(a_val) - 65'(b_val));
			OP_NEG:  alu_val = -a_val;
			default: alu_val = a_val;
		endcase
	end

	// multiplier: one 32x32 partial product per cycle
	assign pp = 64'(ma_q[32*mcnt_q[1] +: 32]) * 64'(mb_q[32*mcnt_q[0] +: 32]);
	always_comb begin
		case (mcnt_q[1:0])
			2'd0:    sh = 8'd0;
			2'd3:    sh = 8'd64;
			default: sh = 8'd32;
		endcase
	end
	assign mres    = (acc_q[127:104] != '0) ? QMAX : acc_q[103:40];
	assign mul_val = make(mneg_q, mres);

	assign div_go = cmd.exec && (cmd.op == OP_DIV);

	fpdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (mag64(a_val)),
		.den    (mag64(b_val)),
		.neg    (a_val[63] ^ b_val[63]),
		.done   (div_done),
		.zero   (div_zero),
		.quo    (div_quo)
	);

	// writeback select: one working register per cycle
	always_comb begin
		wr_en  = 1'b0;
		wr_dst = cmd.dst;
		wr_val = alu_val;
		if (cmd.exec && (cmd.op == OP_ADD || cmd.op == OP_SUB || cmd.op == OP_NEG)) begin
			wr_en = 1'b1;
		end else if (mact_q && mcnt_q == 3'd4) begin
			wr_en  = 1'b1;
			wr_dst = dst_q;
			wr_val = mul_val;
		end else if (div_done && !div_zero) begin
			wr_en  = 1'b1;
			wr_dst = dst_q;
			wr_val = div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q  <= 31'd838861;
			loff_q   <= 32'sd117440512;
			tol_q    <= 25'd168;
			maxatt_q <= 6'd20;
			done_q   <= 1'b0;
			mact_q   <= 1'b0;
			mcnt_q   <= '0;
			ok_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PITCH:  pitch_q  <= cfg_data[30:0];
					CFG_LOFF:   loff_q   <= $signed(cfg_data);
					CFG_TOL:    tol_q    <= cfg_data[24:0];
					CFG_MAXATT: maxatt_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			done_q <= 1'b0;
			if (cmd.exec && (cmd.op == OP_ADD || cmd.op == OP_SUB || cmd.op == OP_NEG))
				done_q <= 1'b1;
			if (cmd.exec && cmd.op == OP_MUL) begin
				mact_q <= 1'b1;
				mcnt_q <= '0;
			end else if (mact_q) begin
				mcnt_q <= mcnt_q + 3'd1;
				if (mcnt_q == 3'd4) begin
					mact_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (cmd.finish) ok_q <= cmd.ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= to_q(65'(coord_x));
			y_q     <= to_q(65'(coord_y));
			p_q     <= to_q({34'd0, pitch_q});
			lo_q    <= to_q(65'(loff_q));
			tol64_q <= mag64(to_q({40'd0, tol_q}));
		end
		if (cmd.exec) dst_q <= cmd.dst;
		if (cmd.exec && cmd.op == OP_MUL) begin
			ma_q   <= mag64(a_val);
			mb_q   <= mag64(b_val);
			mneg_q <= a_val[63] ^ b_val[63];
			acc_q  <= '0;
		end else if (mact_q && mcnt_q != 3'd4) begin
			acc_q <= acc_q + ({64'd0, pp} << sh);
		end
		if (wr_en) begin
			case (wr_dst)
				R_X:  x_q  <= wr_val;
				R_Y:  y_q  <= wr_val;
				R_P:  p_q  <= wr_val;
				R_LO: lo_q <= wr_val;
				R_UX: ux_q <= wr_val;
				R_UY: uy_q <= wr_val;
				R_XO: xo_q <= wr_val;
				R_YO: yo_q <= wr_val;
				R_Q:  q_q  <= wr_val;
				R_T1: t1_q <= wr_val;
				R_T2: t2_q <= wr_val;
				default: ;
			endcase
		end
		if (cmd.finish) begin
			ox_q <= cmd.ok ? $signed(from_q(ux_q)) : '0;
			oy_q <= cmd.ok ? $signed(from_q(uy_q)) : '0;
		end
	end

	assign stat.done    = done_q | div_done;
	assign stat.dz      = div_done & div_zero;
	assign stat.conv    = (mag64(t1_q) < tol64_q) && (mag64(t2_q) < tol64_q);
	assign stat.max_att = maxatt_q;

	assign out_x   = ox_q;
	assign out_y   = oy_q;
	assign success = ok_q;

endmodule

@@ rtl/fpdm_ctrl.sv @@
// Controller: steps the micro-op program, counts inverse passes and
// decides success or failure. Depends on fpdm_pkg.
module fpdm_ctrl import fpdm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  req_type,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	state_t          state_q, state_d;
	logic [PC_W-1:0] pc_q;
	logic [5:0]      n_q;
	instr_t          ins;
	logic            lim;

	assign ins = prog(pc_q);
	assign lim = n_q >= stat.max_att;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_ISSUE;
			S_ISSUE: begin
				if (ins.op == OP_END) state_d = S_OUT;
				else if (ins.op == OP_CHK) begin
					if (lim || stat.conv) state_d = S_OUT;
				end else state_d = S_WAIT;
			end
			S_WAIT:  if (stat.done) state_d = stat.dz ? S_OUT : S_ISSUE;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.op     = ins.op;
		cmd.a      = ins.a;
		cmd.b      = ins.b;
		cmd.dst    = ins.dst;
		case (state_q)
			S_IDLE:  cmd.load = start;
			S_ISSUE: begin
				if (ins.op == OP_END) begin
					cmd.finish = 1'b1;
					cmd.ok     = 1'b1;
				end else if (ins.op == OP_CHK) begin
					cmd.finish = lim || stat.conv;
					cmd.ok     = !lim && stat.conv;
				end else cmd.exec = 1'b1;
			end
			S_WAIT:  cmd.finish = stat.done && stat.dz;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= PC_FWD;
			n_q     <= 6'd1;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				pc_q <= req_type ? PC_INV : PC_FWD;
				n_q  <= 6'd1;
			end else if (state_q == S_WAIT && stat.done && !stat.dz) begin
				pc_q <= pc_q + 6'd1;
			end else if (state_q == S_ISSUE && ins.op == OP_CHK && !lim && !stat.conv) begin
				// not converged: run another pass
				pc_q <= PC_LOOP;
				n_q  <= n_q + 6'd1;
			end
		end
	end

endmodule

@@ rtl/focal_plane_distortion_map.sv @@
// Channel   Ports                                  Transfer
// request   start, busy, req_type, coord_x/y       edge with start high, busy low
// result    done, out_x, out_y, success            edge ending the done cycle
// config    cfg_we, cfg_index, cfg_data            edge with cfg_we high
//
// The bit-serial divider sets the length of a request: a forward request
// runs one division, an inverse request two plus four per pass. Multiplies
// and adds are shorter.
// Reset clears the controller and reloads the register defaults.
// Results are shown for one cycle; the receiver cannot stall them.
// Depends on fpdm_pkg, fpdm_ctrl, fpdm_dp and the defines header.
`include "focal_plane_distortion_map_defines.svh"
module focal_plane_distortion_map import fpdm_pkg::*; #(
	parameter int COORD_WIDTH     = 32,
	parameter int COORD_FRAC_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          success,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	fpdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	fpdm_dp #(
		.COORD_WIDTH     (COORD_WIDTH),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.cmd       (cmd),
		.stat      (stat),
		.out_x     (out_x),
		.out_y     (out_y),
		.success   (success)
	);

	`FPDM_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
	`FPDM_ASSERT_IMP(a_done_busy, done, busy, "result strobe outside a request")
	`FPDM_ASSERT_NXT(a_done_pulse, done, !done && !busy, "result strobe longer than one cycle")
	`FPDM_ASSERT_IMP(a_fail_zero, done && !success, out_x == '0 && out_y == '0,
		"failed result carries nonzero coordinates")

endmodule

@@ verif/focal_plane_distortion_map_test.sv @@
// Self-checking testbench for focal_plane_distortion_map: forward and inverse
// requests under several register settings, checked against a Q24.40 predictor.
// Depends on fpdm_pkg and the RTL of the block.
`timescale 1ns / 1ps
module focal_plane_distortion_map_test import fpdm_pkg::*;;

	localparam logic       REQ_FWD    = 1'b0;
	localparam logic       REQ_INV    = 1'b1;
	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int         SHIFT_IN   = QF - 24;
	localparam logic [63:0] LIM32     = 64'h7fff_ffff;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               ok;
	} mapped_t;

	typedef struct {
		logic               rt;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               typed;
		mapped_t            want;
	} vec_t;

	typedef struct {
		logic [31:0] pitch;
		logic [31:0] loff;
		logic [31:0] tol;
		logic [31:0] att;
		int          n_items;
		logic        near;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start, busy, req_type, done, success, cfg_we;
	logic signed [31:0] coord_x, coord_y, out_x, out_y;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor copy of the registers
	logic [30:0]        pitch_r;
	logic signed [31:0] loff_r;
	logic [24:0]        tol_r;
	logic [5:0]         att_r;

	mapped_t pending_q[$];
	int errors = 0, n_fwd = 0, n_inv = 0, n_conv = 0, n_checked = 0;
	int burst_left = 0;

	focal_plane_distortion_map u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .coord_x(coord_x), .coord_y(coord_y),
		.done(done), .out_x(out_x), .out_y(out_y), .success(success),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] absval(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] signed_sat(input logic neg, input logic [63:0] m);
		logic [63:0] c;
		c = (m > QMAX) ? QMAX : m;
		return neg ? $signed(64'(-c)) : $signed(c);
	endfunction

	function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > $signed({1'b0, QMAX})) return $signed(QMAX);
		if (s < -$signed({1'b0, QMAX})) return -$signed(QMAX);
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] qsub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return qadd(a, signed_sat(b >= 0, absval(b)));
	endfunction

	function automatic logic signed [63:0] qshift(input logic signed [63:0] v, input int k);
		logic [63:0] m;
		m = absval(v);
		if (k >= 0) m = (m > (QMAX >> k)) ? QMAX : (m << k);
		else m = m >> (-k);
		return signed_sat(v < 0, m);
	endfunction

	function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [127:0] p;
		p = (128'(absval(a)) * 128'(absval(b))) >> QF;
		return signed_sat((a < 0) != (b < 0), (p > 128'(QMAX)) ? QMAX : p[63:0]);
	endfunction

	// false on a zero divisor
	function automatic logic qdiv(input logic signed [63:0] a, input logic signed [63:0] b,
			output logic signed [63:0] q);
		logic [127:0] n, d;
		n = 128'(absval(a)) << QF;
		d = 128'(absval(b));
		q = 64'sd0;
		if (d == 0) return 1'b0;
		n = n / d;
		q = signed_sat((a < 0) != (b < 0), (n > 128'(QMAX)) ? QMAX : n[63:0]);
		return 1'b1;
	endfunction

	function automatic logic line_terms(input logic signed [63:0] u, input logic signed [63:0] p,
			input logic signed [63:0] lo, output logic signed [63:0] xo,
			output logic signed [63:0] yo);
		logic signed [63:0] q, t;
		xo = 64'sd0;
		yo = 64'sd0;
		if (!qdiv(u, p, q)) return 1'b0;
		xo = qmul(CX0, qsub(lo, q));
		if (!qdiv(qmul(p, CY0), u, t)) return 1'b0;
		yo = qadd(qsub(t, CY1), qmul(q, CY2));
		return 1'b1;
	endfunction

	function automatic logic signed [31:0] to_q24(input logic signed [63:0] v);
		logic signed [63:0] c;
		logic [63:0] m;
		c = qshift(v, 24 - QF);
		m = absval(c);
		if (m > LIM32) m = LIM32;
		c = signed_sat(c < 0, m);
		return c[31:0];
	endfunction

	function automatic mapped_t map_coords(input logic rt, input logic signed [31:0] cx,
			input logic signed [31:0] cy);
		logic signed [63:0] x, y, p, lo, rx, ry, j, nj, dj, cb1, xo, yo, ux, uy, gx, gy;
		logic [63:0] tol;
		logic ok, conv;
		int n;
		mapped_t r;
		x = qshift({{32{cx[31]}}, cx}, SHIFT_IN);
		y = qshift({{32{cy[31]}}, cy}, SHIFT_IN);
		p = qshift({33'd0, pitch_r}, SHIFT_IN);
		lo = qshift({{32{loff_r[31]}}, loff_r}, SHIFT_IN);
		tol = absval(qshift({39'd0, tol_r}, SHIFT_IN));
		rx = 0;
		ry = 0;
		ok = 1'b0;
		if (rt == REQ_FWD) begin
			if (qdiv(y, p, j)) begin
				nj = signed_sat(j >= 0, absval(j));
				dj = qadd(qadd(CY0, qmul(CY1, nj)), qmul(qmul(CY2, nj), nj));
				cb1 = qmul(CX0, qadd(nj, lo));
				rx = qmul(x, qadd(ONE_Q, cb1));
				ry = qmul(p, qadd(j, dj));
				ok = 1'b1;
			end
		end else if (line_terms(y, p, lo, xo, yo)) begin
			for (n = 1; ; n++) begin
				if (!qdiv(x, qadd(ONE_Q, xo), ux)) break;
				if (!qdiv(y, qadd(ONE_Q, yo), uy)) break;
				if (!line_terms(uy, p, lo, xo, yo)) break;
				gx = qmul(ux, qadd(ONE_Q, xo));
				gy = qmul(uy, qadd(ONE_Q, yo));
				conv = absval(qsub(gy, y)) < tol && absval(qsub(gx, x)) < tol;
				if (n + 1 > int'(att_r)) break;
				if (conv) begin
					rx = ux;
					ry = uy;
					ok = 1'b1;
					break;
				end
			end
		end
		r.x = ok ? to_q24(rx) : 32'sd0;
		r.y = ok ? to_q24(ry) : 32'sd0;
		r.ok = ok;
		return r;
	endfunction

	// Enter at a rising edge; return at the edge of the transfer, or after a random idle gap with start low.
	task automatic send(input vec_t v);
		int gap;
		start <= 1'b1;
		req_type <= v.rt;
		coord_x <= v.x;
		coord_y <= v.y;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.push_back(v.typed ? v.want : map_coords(v.rt, v.x, v.y));
		if (v.rt == REQ_FWD) n_fwd++;
		else n_inv++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 5);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 600) : $urandom_range(0, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic apply_setting(input setting_t s);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PITCH;
		cfg_data <= s.pitch;
		@(posedge clk);
		cfg_index <= CFG_LOFF;
		cfg_data <= s.loff;
		@(posedge clk);
		cfg_index <= CFG_TOL;
		cfg_data <= s.tol;
		@(posedge clk);
		cfg_index <= CFG_MAXATT;
		cfg_data <= s.att;
		@(posedge clk);
		// unmapped index: must be ignored
		cfg_index <= CFG_UNUSED;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		pitch_r = s.pitch[30:0];
		loff_r = s.loff;
		tol_r = s.tol[24:0];
		att_r = s.att[5:0];
	endtask

	function automatic logic signed [31:0] pick_coord(input logic near);
		if (near && $urandom_range(0, 4) != 0)
			return $signed(32'($urandom_range(0, 32'h0800_0000))) - 32'sh0400_0000;
		return $signed($urandom);
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$error("result with nothing expected: x=%0d y=%0d success=%0b",
					out_x, out_y, success);
				errors++;
			end else begin
				mapped_t w;
				w = pending_q.pop_front();
				n_checked++;
				if (success) n_conv++;
				if (out_x !== w.x) begin
					$error("out_x: expected %0d, got %0d", w.x, out_x);
					errors++;
				end
				if (out_y !== w.y) begin
					$error("out_y: expected %0d, got %0d", w.y, out_y);
					errors++;
				end
				if (success !== w.ok) begin
					$error("success: expected %0b, got %0b", w.ok, success);
					errors++;
				end
			end
		end
	end

	initial begin
		vec_t dir[$];
		setting_t plan[$];
		setting_t s;
		vec_t v;
		mapped_t fail_r;
		fail_r = '{32'sd0, 32'sd0, 1'b0};
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_FWD;
		coord_x = '0;
		coord_y = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_PITCH;
		cfg_data = '0;
		pitch_r = 31'd838861;
		loff_r = 32'sd117440512;
		tol_r = 25'd168;
		att_r = 6'd20;

		// directed rows; typed ones fail on a zero along-track divisor
		dir = '{
			'{REQ_FWD, 32'sd0, 32'sd0, 1'b0, fail_r},
			'{REQ_FWD, 32'sh7fffffff, 32'sh7fffffff, 1'b0, fail_r},
			'{REQ_FWD, -32'sh80000000, -32'sh80000000, 1'b0, fail_r},
			'{REQ_FWD, -32'sh80000000, 32'sh7fffffff, 1'b0, fail_r},
			'{REQ_FWD, 32'sh01000000, -32'sh01000000, 1'b0, fail_r},
			'{REQ_FWD, -32'sd1, 32'sd1, 1'b0, fail_r},
			'{REQ_INV, 32'sd0, 32'sd0, 1'b1, fail_r},
			'{REQ_INV, 32'sh7fffffff, 32'sd0, 1'b1, fail_r},
			'{REQ_INV, -32'sh80000000, 32'sd0, 1'b1, fail_r},
			'{REQ_INV, 32'sh01000000, 32'sh01000000, 1'b0, fail_r},
			'{REQ_INV, -32'sh00800000, 32'sh02000000, 1'b0, fail_r},
			'{REQ_INV, 32'sh7fffffff, 32'sh7fffffff, 1'b0, fail_r},
			'{REQ_INV, -32'sh80000000, -32'sh80000000, 1'b0, fail_r},
			'{REQ_INV, 32'sd0, 32'sd1, 1'b0, fail_r},
			'{REQ_INV, -32'sd1, -32'sd1, 1'b0, fail_r}
		};
		plan = '{
			'{32'd838861, 32'd117440512, 32'd168, 32'd20, 100, 1'b1},
			'{32'h7fffffff, 32'h80000000, 32'd16777216, 32'd63, 15, 1'b1},
			'{32'd1, 32'h7fffffff, 32'd0, 32'd1, 20, 1'b1},
			'{32'd838861, 32'd117440512, 32'd168, 32'd63, 10, 1'b1},
			'{32'd0, 32'd0, 32'd168, 32'd0, 10, 1'b0},
			'{32'd838861, 32'd117440512, 32'd5000, 32'd6, 70, 1'b1},
			'{32'd0, 32'd0, 32'd0, 32'd0, 60, 1'b0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) send(dir[i]);
		drain();

		foreach (plan[p]) begin
			s = plan[p];
			if (p == plan.size() - 1) begin
				s.pitch = $urandom;
				s.loff = $urandom;
				s.tol = $urandom_range(0, 1 << 24);
				s.att = $urandom_range(2, 8);
			end
			apply_setting(s);
			@(posedge clk);
			repeat (s.n_items) begin
				v.rt = 1'($urandom_range(0, 1));
				v.x = pick_coord(s.near);
				v.y = pick_coord(s.near);
				v.typed = 1'b0;
				v.want = fail_r;
				send(v);
			end
			drain();
		end

		repeat (50) @(posedge clk);
		$display("Covered %0d forward and %0d inverse requests over %0d register settings;",
			n_fwd, n_inv, plan.size() + 1);
		$display("%0d results checked, %0d of them successful mappings.", n_checked, n_conv);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#400_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
